### sv/pfrag_pkg.sv
// shared widths, codes and slot record for the paced frame fragmenter
package pfrag_pkg;
	localparam int LEN_W  = 16;
	localparam int FB_W   = 11;
	localparam int WIN_W  = 8;
	localparam int TS_W   = 32;
	localparam int CR_W   = 6;
	localparam int SEQ_W  = 32;
	localparam int FRAG_W = 8;
	localparam int SLOT_W = 3;
	localparam int OFF_W  = 14;
	localparam int DROP_W = 32;
	localparam int QF_W   = 4;
	localparam int IDX_W  = 1;

	localparam logic [FB_W-1:0]  FB_RESET  = 11'd1400;
	localparam logic [WIN_W-1:0] WIN_RESET = 8'd25;

	localparam int DEF_SLOTS       = 8;
	localparam int DEF_SLOT_BYTES  = 15104;
	localparam int DEF_MAX_CREDITS = 32;

	localparam logic [IDX_W-1:0] CFG_FRAG_BYTES = 1'b0;
	localparam logic [IDX_W-1:0] CFG_DRAIN_WIN  = 1'b1;

	localparam logic KIND_ENQ  = 1'b0;
	localparam logic KIND_PUMP = 1'b1;

	localparam logic ITEM_FRAG   = 1'b0;
	localparam logic ITEM_STATUS = 1'b1;

	localparam logic [1:0] MODE_INLINE = 2'd0;
	localparam logic [1:0] MODE_FLUSH  = 2'd1;
	localparam logic [1:0] MODE_PUMP   = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [SEQ_W-1:0]  seq;
		logic [FRAG_W-1:0] total;
		logic [FRAG_W-1:0] next;
	} slot_t;
endpackage

### sv/pfrag_if.sv
// handshake channels: command items, result items, register writes
interface pfrag_cmd_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] frame_len;
	logic [31:0] now_ms;
	logic        link_ok;
	logic [5:0]  credits;
	modport source(output valid, kind, frame_len, now_ms, link_ok, credits, input ready);
	modport sink(input valid, kind, frame_len, now_ms, link_ok, credits, output ready);
endinterface

interface pfrag_rsp_if;
	logic        valid;
	logic        ready;
	logic        item_type;
	logic [31:0] frame_seq;
	logic [7:0]  frag_index;
	logic [7:0]  frag_total;
	logic [2:0]  slot_index;
	logic [13:0] byte_offset;
	logic [10:0] byte_count;
	logic        accepted;
	logic [3:0]  queued_frames;
	logic [31:0] dropped_frames;
	logic        last;
	modport source(output valid, item_type, frame_seq, frag_index, frag_total, slot_index,
		byte_offset, byte_count, accepted, queued_frames, dropped_frames, last, input ready);
	modport sink(input valid, item_type, frame_seq, frag_index, frag_total, slot_index,
		byte_offset, byte_count, accepted, queued_frames, dropped_frames, last, output ready);
endinterface

interface pfrag_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [10:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### sv/pfrag_div.sv
// shared restoring divider, one quotient bit per cycle
module pfrag_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quot_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

### sv/pfrag_mem.sv
// frame slot ring storage, one write and one registered read port
module pfrag_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  pfrag_pkg::slot_t wdata,
	input  logic [AW-1:0]    raddr,
	output pfrag_pkg::slot_t rdata
);
	import pfrag_pkg::*;

	slot_t mem [DEPTH];
	slot_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;
endmodule

### sv/paced_frame_fragmenter_top.sv
// paced frame fragmenter: slot ring, sequencer and shared divider
// One command is worked on at a time and cmd.ready is low until its closing status
// is loaded into the output register. Enqueues and pumps share one bit-serial divider
// of PEND_W+33 bits (44 bits at 8 slots): an enqueue runs the divide for the
// fragment count and then sends fragments (flush and inline); a pump with frames queued
// sums the pending fragments over the queued frames, multiplies, runs the budget
// divide and then sends fragments. Pumps with an empty ring, link down or no elapsed
// time, and enqueues rejected on their inputs, go straight to the closing status. Each
// result waits for rsp.ready; the slot store has no reset and needs no clearing pass.
module paced_frame_fragmenter_top #(
	parameter int SLOTS       = pfrag_pkg::DEF_SLOTS,
	parameter int SLOT_BYTES  = pfrag_pkg::DEF_SLOT_BYTES,
	parameter int MAX_CREDITS = pfrag_pkg::DEF_MAX_CREDITS
) (
	input logic        clk,
	input logic        arst_n,
	pfrag_cmd_if.sink  cmd,
	pfrag_rsp_if.source rsp,
	pfrag_cfg_if.sink  cfg
);
	import pfrag_pkg::*;

	localparam int PTR_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int PEND_W = $clog2(SLOTS * 255 + 1);
	localparam int PROD_W = PEND_W + TS_W;
	localparam int DIV_W  = PROD_W + 1;
	localparam int MUL_W  = FRAG_W + FB_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DIVGO   = 4'd1;
	localparam logic [3:0] ST_DIV     = 4'd2;
	localparam logic [3:0] ST_SUM_RD  = 4'd3;
	localparam logic [3:0] ST_SUM_ACC = 4'd4;
	localparam logic [3:0] ST_MUL     = 4'd5;
	localparam logic [3:0] ST_STORE   = 4'd6;
	localparam logic [3:0] ST_CHK     = 4'd7;
	localparam logic [3:0] ST_MULOFF  = 4'd8;
	localparam logic [3:0] ST_SEND    = 4'd9;
	localparam logic [3:0] ST_STAT    = 4'd10;

	logic [3:0]        state_q;
	logic [FB_W-1:0]   fb_q;
	logic [WIN_W-1:0]  win_q;
	logic [PTR_W-1:0]  wp_q, rp_q, scan_q;
	logic [CNT_W-1:0]  cnt_q, idx_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TS_W-1:0]   last_ms_q, elapsed_q;
	logic [DROP_W-1:0] drop_q;
	logic              kind_q, acc_q;
	logic [LEN_W-1:0]  len_q;
	logic [CR_W-1:0]   credit_q, budget_q;
	logic [1:0]        mode_q;
	logic [FRAG_W-1:0] total_q;
	logic [PEND_W-1:0] pend_q;
	logic [PROD_W-1:0] prod_q;
	logic [MUL_W-1:0]  off_q;

	logic              out_valid_q;
	logic              o_type_q, o_acc_q, o_last_q;
	logic [SEQ_W-1:0]  o_seq_q;
	logic [FRAG_W-1:0] o_idx_q, o_total_q;
	logic [SLOT_W-1:0] o_slot_q;
	logic [OFF_W-1:0]  o_off_q;
	logic [FB_W-1:0]   o_cnt_q;
	logic [QF_W-1:0]   o_qf_q;
	logic [DROP_W-1:0] o_drop_q;

	slot_t             rd_slot, wr_slot;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_waddr, mem_raddr;

	logic              div_start, div_done;
	logic [DIV_W-1:0]  div_num, div_quot;
	logic [FB_W-1:0]   div_den;
	logic [WIN_W-1:0]  win_eff;

	logic              cmd_fire, out_free, out_load;
	logic [CR_W-1:0]   cr_cap;
	logic [TS_W-1:0]   elapsed_now;
	logic [DROP_W:0]   drop_sum;
	logic [MUL_W-1:0]  len_ext, off_diff;
	logic [FB_W-1:0]   frag_cnt;
	logic [FRAG_W-1:0] next_inc;
	logic [FRAG_W-1:0] pend_diff;
	logic              enq_bad;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;
	// output register takes a new result this cycle
	assign out_load  = ((state_q == ST_SEND) || (state_q == ST_STAT)) && out_free;

	assign cr_cap      = (cmd.credits > CR_W'(MAX_CREDITS)) ? CR_W'(MAX_CREDITS) : cmd.credits;
	assign elapsed_now = cmd.now_ms - last_ms_q;
	assign drop_sum    = {1'b0, drop_q} + (DROP_W + 1)'(cnt_q);
	assign enq_bad     = !cmd.link_ok || (cmd.frame_len == '0)
		|| (32'(cmd.frame_len) > 32'(SLOT_BYTES)) || (fb_q == '0);
	assign win_eff     = (win_q == '0) ? WIN_W'(1) : win_q;

	// shared divider: fragment count on enqueue, paced budget on pump
	assign div_start = (state_q == ST_DIVGO);
	always_comb begin
		if (kind_q == KIND_ENQ) begin
			div_num = DIV_W'(len_q) + DIV_W'(fb_q) - DIV_W'(1);
			div_den = fb_q;
		end else begin
			div_num = DIV_W'(prod_q) + DIV_W'(win_eff) - DIV_W'(1);
			div_den = FB_W'(win_eff);
		end
	end

	pfrag_div #(.NUM_W(DIV_W), .DEN_W(FB_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// fragment length from the registered offset
	assign len_ext  = MUL_W'(rd_slot.length);
	assign off_diff = len_ext - off_q;
	assign frag_cnt = (off_q >= len_ext) ? '0
		: ((off_diff > MUL_W'(fb_q)) ? fb_q : off_diff[FB_W-1:0]);
	assign next_inc = rd_slot.next + 1'b1;
	assign pend_diff = (rd_slot.total > rd_slot.next) ? rd_slot.total - rd_slot.next : '0;

	assign mem_raddr = (state_q == ST_SUM_RD) ? scan_q : rp_q;
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rp_q;
		wr_slot   = rd_slot;
		if (state_q == ST_STORE) begin
			mem_we         = 1'b1;
			mem_waddr      = wp_q;
			wr_slot.length = len_q;
			wr_slot.seq    = seq_q;
			wr_slot.total  = total_q;
			wr_slot.next   = '0;
		end else if (state_q == ST_SEND && out_free) begin
			mem_we       = 1'b1;
			wr_slot.next = next_inc;
		end
	end

	pfrag_mem #(.DEPTH(SLOTS), .AW(PTR_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wr_slot),
		.raddr (mem_raddr),
		.rdata (rd_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fb_q        <= FB_RESET;
			win_q       <= WIN_RESET;
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			seq_q       <= '0;
			last_ms_q   <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_FRAG_BYTES: fb_q  <= cfg.data;
					CFG_DRAIN_WIN:  win_q <= cfg.data[WIN_W-1:0];
					default: ;
				endcase
			end
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.kind == KIND_ENQ) begin
							if (enq_bad) begin
								acc_q   <= 1'b0;
								state_q <= ST_STAT;
							end else begin
								state_q <= ST_DIVGO;
							end
						end else if (cnt_q == '0) begin
							last_ms_q <= cmd.now_ms;
							acc_q     <= 1'b1;
							state_q   <= ST_STAT;
						end else if (!cmd.link_ok) begin
							drop_q  <= drop_sum[DROP_W] ? '1 : drop_sum[DROP_W-1:0];
							wp_q    <= '0;
							rp_q    <= '0;
							cnt_q   <= '0;
							acc_q   <= 1'b1;
							state_q <= ST_STAT;
						end else if (elapsed_now == '0) begin
							acc_q   <= 1'b1;
							state_q <= ST_STAT;
						end else begin
							last_ms_q <= cmd.now_ms;
							state_q   <= ST_SUM_RD;
						end
					end
				end
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (kind_q == KIND_ENQ) begin
							if (|div_quot[DIV_W-1:FRAG_W]) begin
								acc_q   <= 1'b0;
								state_q <= ST_STAT;
							end else if (cnt_q >= CNT_W'(SLOTS)) begin
								state_q <= ST_CHK;
							end else begin
								state_q <= ST_STORE;
							end
						end else begin
							state_q <= ST_CHK;
						end
					end
				end
				ST_SUM_RD: state_q <= ST_SUM_ACC;
				ST_SUM_ACC: begin
					if (idx_q + 1'b1 == cnt_q) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SUM_RD;
					end
				end
				ST_MUL: state_q <= ST_DIVGO;
				ST_STORE: begin
					wp_q    <= ptr_inc(wp_q);
					cnt_q   <= cnt_q + 1'b1;
					seq_q   <= seq_q + 1'b1;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (cnt_q != '0 && credit_q != '0 && budget_q != '0) begin
						state_q <= ST_MULOFF;
					end else if (mode_q == MODE_FLUSH) begin
						if (cnt_q >= CNT_W'(SLOTS)) begin
							acc_q   <= 1'b0;
							state_q <= ST_STAT;
						end else begin
							state_q <= ST_STORE;
						end
					end else begin
						acc_q   <= 1'b1;
						state_q <= ST_STAT;
					end
				end
				ST_MULOFF: state_q <= ST_SEND;
				ST_SEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (next_inc >= rd_slot.total) begin
							rp_q  <= ptr_inc(rp_q);
							cnt_q <= cnt_q - 1'b1;
						end
						state_q <= ST_CHK;
					end
				end
				ST_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q    <= cmd.kind;
				len_q     <= cmd.frame_len;
				credit_q  <= cr_cap;
				elapsed_q <= elapsed_now;
				scan_q    <= rp_q;
				idx_q     <= '0;
				pend_q    <= '0;
			end
			ST_DIV: begin
				total_q <= div_quot[FRAG_W-1:0];
				if (kind_q == KIND_ENQ) begin
					mode_q   <= MODE_FLUSH;
					budget_q <= '1;
				end else begin
					mode_q <= MODE_PUMP;
					if (|div_quot[DIV_W-1:CR_W]) begin
						budget_q <= '1;
					end else if (div_quot == '0) begin
						budget_q <= CR_W'(1);
					end else begin
						budget_q <= div_quot[CR_W-1:0];
					end
				end
			end
			ST_SUM_ACC: begin
				pend_q <= pend_q + PEND_W'(pend_diff);
				scan_q <= ptr_inc(scan_q);
				idx_q  <= idx_q + 1'b1;
			end
			ST_MUL: prod_q <= PROD_W'(pend_q * elapsed_q);
			ST_STORE: begin
				mode_q   <= MODE_INLINE;
				budget_q <= CR_W'(1);
			end
			ST_MULOFF: off_q <= MUL_W'(rd_slot.next * fb_q);
			ST_SEND: begin
				if (out_free) begin
					credit_q  <= credit_q - 1'b1;
					budget_q  <= budget_q - 1'b1;
					o_type_q  <= ITEM_FRAG;
					o_seq_q   <= rd_slot.seq;
					o_idx_q   <= rd_slot.next;
					o_total_q <= rd_slot.total;
					o_slot_q  <= SLOT_W'(rp_q);
					o_off_q   <= off_q[OFF_W-1:0];
					o_cnt_q   <= frag_cnt;
					o_acc_q   <= 1'b0;
					o_qf_q    <= '0;
					o_drop_q  <= '0;
					o_last_q  <= 1'b0;
				end
			end
			ST_STAT: begin
				if (out_free) begin
					o_type_q  <= ITEM_STATUS;
					o_seq_q   <= '0;
					o_idx_q   <= '0;
					o_total_q <= '0;
					o_slot_q  <= '0;
					o_off_q   <= '0;
					o_cnt_q   <= '0;
					o_acc_q   <= acc_q;
					o_qf_q    <= QF_W'(cnt_q);
					o_drop_q  <= drop_q;
					o_last_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.item_type      = o_type_q;
	assign rsp.frame_seq      = o_seq_q;
	assign rsp.frag_index     = o_idx_q;
	assign rsp.frag_total     = o_total_q;
	assign rsp.slot_index     = o_slot_q;
	assign rsp.byte_offset    = o_off_q;
	assign rsp.byte_count     = o_cnt_q;
	assign rsp.accepted       = o_acc_q;
	assign rsp.queued_frames  = o_qf_q;
	assign rsp.dropped_frames = o_drop_q;
	assign rsp.last           = o_last_q;
endmodule
